>>> src/button_date_editor_core_macros.svh
// assertion macros for the button date editor
`ifndef BUTTON_DATE_EDITOR_CORE_MACROS_SVH
`define BUTTON_DATE_EDITOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define BDE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BDE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define BDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/bde_pkg.sv
// types, constants and date functions shared by the date editor
`timescale 1ns / 1ps

package bde_pkg;

	localparam int YEAR_W    = 14;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int FIELD_W   = 2;
	localparam int BTN_W     = 2;
	localparam int CFG_IDX_W = 2;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;

	typedef enum logic [FIELD_W-1:0] {
		FIELD_YEAR  = 2'd0,
		FIELD_MONTH = 2'd1,
		FIELD_DAY   = 2'd2
	} field_t;

	typedef enum logic [BTN_W-1:0] {
		BTN_UP   = 2'd0,
		BTN_DOWN = 2'd1,
		BTN_NEXT = 2'd2,
		BTN_BACK = 2'd3
	} button_t;

	localparam logic KIND_BUTTON = 1'b0;
	localparam logic KIND_ENTER  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_YEAR_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_MAX = 2'd1;

	localparam year_t  YEAR_MIN_RST = 14'd2020;
	localparam year_t  YEAR_MAX_RST = 14'd2035;
	localparam year_t  YEAR_RST     = 14'd2024;
	localparam month_t MONTH_RST    = 4'd1;
	localparam day_t   DAY_RST      = 5'd1;

	localparam month_t MONTH_FIRST = 4'd1;
	localparam month_t MONTH_LAST  = 4'd12;
	localparam day_t   DAY_FIRST   = 5'd1;

	// 25 * INV25 == 1 mod 2^14; n is a multiple of 25 iff n * INV25 mod 2^14 <= DIV25_LIM
	localparam year_t INV25     = 14'd7209;
	localparam year_t DIV25_LIM = 14'd655;

	typedef struct packed {
		year_t  year;
		month_t month;
		day_t   day;
		field_t field;
	} date_state_t;

	typedef struct packed {
		year_t year_min;
		year_t year_max;
	} year_limits_t;

	// gregorian rule: leap iff div by 4 and (not div by 100 or div by 400)
	function automatic logic is_leap(year_t y);
		logic [2*YEAR_W-1:0] prod;
		logic                div25;
		prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
		div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic day_t month_length(month_t m, logic leap);
		day_t len;
		unique case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> src/bde_item_if.sv
// input channel: one button or enter word
`timescale 1ns / 1ps

interface bde_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [bde_pkg::BTN_W-1:0]  button;

	modport source (output valid, output kind, output button, input ready);
	modport sink   (input valid, input kind, input button, output ready);
endinterface

>>> src/bde_result_if.sv
// output channel: date, field and leave flag after each word
`timescale 1ns / 1ps

interface bde_result_if;
	logic                         valid;
	logic                         ready;
	logic [bde_pkg::YEAR_W-1:0]   year_value;
	logic [bde_pkg::MONTH_W-1:0]  month_value;
	logic [bde_pkg::DAY_W-1:0]    day_value;
	logic [bde_pkg::FIELD_W-1:0]  field_sel;
	logic                         leave;

	modport source (output valid, output year_value, output month_value, output day_value,
		output field_sel, output leave, input ready);
	modport sink   (input valid, input year_value, input month_value, input day_value,
		input field_sel, input leave, output ready);
endinterface

>>> src/bde_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface bde_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bde_pkg::CFG_IDX_W-1:0]   index;
	logic [bde_pkg::YEAR_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/button_date_editor_core.sv
// button date editor top level: input register, one step of date logic, result register
// a word goes from the input register through the step logic into the result register
// throughput: one word per cycle unless stalled; the date state updates as a word lands
// reset: arst_n clears the pipeline valids and loads 2024-01-01, year field, limits 2020..2035
// config writes always accepted; the limits are registered
`timescale 1ns / 1ps

`include "button_date_editor_core_macros.svh"

module button_date_editor_core (
	input  logic          clk,
	input  logic          arst_n,
	bde_item_if.sink      item,
	bde_result_if.source  result,
	bde_cfg_if.sink       cfg
);

	// input register stage
	logic                           valid_s1;
	logic                           kind_s1;
	logic [bde_pkg::BTN_W-1:0]      button_s1;

	// date state, which is also the result payload
	bde_pkg::date_state_t           state_q;
	logic                           leave_q;
	logic                           res_valid_q;

	bde_pkg::year_limits_t          limits;
	bde_pkg::date_state_t           state_nxt;
	logic                           leave_nxt;
	logic                           adv;
	logic                           item_acc;

	// limit registers
	bde_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	// step logic between the input register and the state / result register
	bde_step u_step (
		.cur    (state_q),
		.kind   (kind_s1),
		.button (button_s1),
		.limits (limits),
		.nxt    (state_nxt),
		.leave  (leave_nxt)
	);

	// the word in stage 1 moves on when the result register is empty or being drained
	assign adv      = valid_s1 && (!res_valid_q || result.ready);
	// stage 1 takes a new word when empty or emptying this cycle
	assign item.ready = !valid_s1 || adv;
	assign item_acc   = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of stage 1, no reset needed
	always_ff @(posedge clk) begin
		if (item_acc) begin
			kind_s1   <= item.kind;
			button_s1 <= item.button;
		end
	end

	// date state; its value after each word is the word's result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.year  <= bde_pkg::YEAR_RST;
			state_q.month <= bde_pkg::MONTH_RST;
			state_q.day   <= bde_pkg::DAY_RST;
			state_q.field <= bde_pkg::FIELD_YEAR;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leave_q <= leave_nxt;
		end
	end

	// result valid: set when a word lands, cleared when taken with nothing behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.year_value  = state_q.year;
	assign result.month_value = state_q.month;
	assign result.day_value   = state_q.day;
	assign result.field_sel   = state_q.field;
	assign result.leave       = leave_q;

	// checks
	`BDE_ASSERT_NEXT(a_adv_shows, clk, arst_n, adv, result.valid, "advanced word not shown")
	`BDE_ASSERT_IMPLY(a_day_nonzero, clk, arst_n, result.valid, result.day_value != '0, "day is zero")
	`BDE_ASSERT_IMPLY(a_month_range, clk, arst_n, result.valid,
		result.month_value >= bde_pkg::MONTH_FIRST && result.month_value <= bde_pkg::MONTH_LAST,
		"month out of range")
	`BDE_ASSERT_IMPLY(a_leave_field, clk, arst_n, result.valid && result.leave,
		result.field_sel == bde_pkg::FIELD_YEAR || result.field_sel == bde_pkg::FIELD_DAY,
		"leave raised from month field")
	`BDE_ASSERT_NEXT(a_enter_year, clk, arst_n, adv && kind_s1 == bde_pkg::KIND_ENTER,
		result.field_sel == bde_pkg::FIELD_YEAR && !result.leave, "enter did not select year")

endmodule

>>> src/bde_cfg_regs.sv
// year limit registers behind the configuration write channel
`timescale 1ns / 1ps

module bde_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	bde_cfg_if.sink               cfg,
	output bde_pkg::year_limits_t limits
);

	bde_pkg::year_limits_t limits_q;

	assign cfg.ready = 1'b1;
	assign limits    = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.year_min <= bde_pkg::YEAR_MIN_RST;
			limits_q.year_max <= bde_pkg::YEAR_MAX_RST;
		end else if (cfg.valid) begin
			// unknown indexes are dropped
			if (cfg.index == bde_pkg::REG_YEAR_MIN) begin
				limits_q.year_min <= cfg.data;
			end else if (cfg.index == bde_pkg::REG_YEAR_MAX) begin
				limits_q.year_max <= cfg.data;
			end
		end
	end

endmodule

>>> src/bde_step.sv
// next date, field and leave flag for one word
`timescale 1ns / 1ps

module bde_step (
	input  bde_pkg::date_state_t              cur,
	input  logic                              kind,
	input  logic [bde_pkg::BTN_W-1:0]         button,
	input  bde_pkg::year_limits_t             limits,
	output bde_pkg::date_state_t              nxt,
	output logic                              leave
);

	logic [bde_pkg::YEAR_W:0]   year_inc;
	bde_pkg::year_t             year_dec;
	bde_pkg::year_t             year_up;
	bde_pkg::year_t             year_down;
	bde_pkg::month_t            month_up;
	bde_pkg::month_t            month_down;
	bde_pkg::button_t           btn;
	bde_pkg::date_state_t       pre;
	logic                       stepped;
	logic                       day_up;
	logic                       day_down;
	bde_pkg::day_t              len;
	logic [bde_pkg::DAY_W:0]    day_inc;

	assign btn = bde_pkg::button_t'(button);

	// candidate values for each field
	always_comb begin
		year_inc = {1'b0, cur.year} + {{bde_pkg::YEAR_W{1'b0}}, 1'b1};
		year_dec = cur.year - bde_pkg::year_t'(1);
		if (year_inc > {1'b0, limits.year_max}) begin
			year_up = limits.year_min;
		end else begin
			year_up = year_inc[bde_pkg::YEAR_W-1:0];
		end
		if (cur.year == '0 || year_dec < limits.year_min) begin
			year_down = limits.year_max;
		end else begin
			year_down = year_dec;
		end
		month_up   = (cur.month >= bde_pkg::MONTH_LAST) ? bde_pkg::MONTH_FIRST
			: cur.month + bde_pkg::month_t'(1);
		month_down = (cur.month <= bde_pkg::MONTH_FIRST) ? bde_pkg::MONTH_LAST
			: cur.month - bde_pkg::month_t'(1);
	end

	// field and button decode
	always_comb begin
		pre      = cur;
		leave    = 1'b0;
		stepped  = 1'b0;
		day_up   = 1'b0;
		day_down = 1'b0;
		if (kind == bde_pkg::KIND_ENTER) begin
			pre.field = bde_pkg::FIELD_YEAR;
		end else begin
			unique case (cur.field)
				bde_pkg::FIELD_YEAR: begin
					unique case (btn)
						bde_pkg::BTN_UP: begin
							pre.year = year_up;
							stepped  = 1'b1;
						end
						bde_pkg::BTN_DOWN: begin
							pre.year = year_down;
							stepped  = 1'b1;
						end
						bde_pkg::BTN_NEXT: pre.field = bde_pkg::FIELD_MONTH;
						bde_pkg::BTN_BACK: leave     = 1'b1;
					endcase
				end
				bde_pkg::FIELD_MONTH: begin
					unique case (btn)
						bde_pkg::BTN_UP: begin
							pre.month = month_up;
							stepped   = 1'b1;
						end
						bde_pkg::BTN_DOWN: begin
							pre.month = month_down;
							stepped   = 1'b1;
						end
						bde_pkg::BTN_NEXT: pre.field = bde_pkg::FIELD_DAY;
						bde_pkg::BTN_BACK: pre.field = bde_pkg::FIELD_YEAR;
					endcase
				end
				bde_pkg::FIELD_DAY: begin
					unique case (btn)
						bde_pkg::BTN_UP: begin
							day_up  = 1'b1;
							stepped = 1'b1;
						end
						bde_pkg::BTN_DOWN: begin
							day_down = 1'b1;
							stepped  = 1'b1;
						end
						bde_pkg::BTN_NEXT: leave     = 1'b1;
						bde_pkg::BTN_BACK: pre.field = bde_pkg::FIELD_MONTH;
					endcase
				end
				default: ;
			endcase
		end
	end

	// day step and clamp; month and year are unchanged when the day steps
	always_comb begin
		len     = bde_pkg::month_length(pre.month, bde_pkg::is_leap(pre.year));
		day_inc = {1'b0, cur.day} + {{bde_pkg::DAY_W{1'b0}}, 1'b1};
		nxt     = pre;
		if (day_up) begin
			nxt.day = (day_inc > {1'b0, len}) ? bde_pkg::DAY_FIRST : day_inc[bde_pkg::DAY_W-1:0];
		end else if (day_down) begin
			nxt.day = (cur.day <= bde_pkg::DAY_FIRST) ? len : cur.day - bde_pkg::day_t'(1);
		end
		if (stepped && nxt.day > len) begin
			nxt.day = len;
		end
	end

endmodule
